[rtl/ase_pkg.sv]
// Shared types and constants of the A64 subset execute core.
`timescale 1ns / 1ps
package ase_pkg;

  typedef enum logic [4:0] {
    K_ADD, K_ADDS, K_AND, K_ANDS, K_BR, K_EOR, K_MUL, K_ORR, K_SDIV, K_UDIV,
    K_SUB, K_SUBS, K_LSL, K_LSR, K_HLT, K_ADDI, K_ADDIS, K_SUBI, K_SUBIS,
    K_LDUR, K_STUR, K_LDURB, K_LDURH, K_STURB, K_STURH, K_STURW,
    K_B, K_BL, K_CBNZ, K_CBZ, K_BCOND, K_MOVZ
  } kind_e;

  localparam logic OP_EXEC    = 1'b0;
  localparam logic OP_PRELOAD = 1'b1;

  localparam logic CFG_START_PC  = 1'b0;
  localparam logic CFG_DATA_BASE = 1'b1;

  localparam logic [31:0] START_PC_RST  = 32'h0040_0000;
  localparam logic [31:0] DATA_BASE_RST = 32'h1000_0000;

  localparam logic [4:0] COND_EQ = 5'h00;
  localparam logic [4:0] COND_NE = 5'h01;
  localparam logic [4:0] COND_GE = 5'h0A;
  localparam logic [4:0] COND_LT = 5'h0B;
  localparam logic [4:0] COND_GT = 5'h0C;
  localparam logic [4:0] COND_LE = 5'h0D;

  localparam logic [4:0] LINK_REG = 5'd30;
  localparam logic [4:0] ZR_REG   = 5'd31;

  typedef struct packed {
    logic        opcode;
    logic [31:0] instruction;
    logic [9:0]  preload_index;
    logic [31:0] preload_value;
    kind_e       kind;
  } item_t;

endpackage

[rtl/ase_front.sv]
// Front end: classifies an incoming instruction word into an operation kind.
`timescale 1ns / 1ps
module ase_front (
  input  logic [31:0]   instruction_i,
  output ase_pkg::kind_e kind_o
);

  logic [10:0] top11;
  logic [9:0]  top10;
  logic [7:0]  top8;
  logic [5:0]  top6;
  logic [8:0]  top9;
  logic [5:0]  fld;
  logic [4:0]  cond;
  logic        hit;

  assign top11 = instruction_i[31:21];
  assign top10 = instruction_i[31:22];
  assign top9  = instruction_i[31:23];
  assign top8  = instruction_i[31:24];
  assign top6  = instruction_i[31:26];
  assign fld   = instruction_i[15:10];
  assign cond  = instruction_i[4:0];

  // priority chain of encoding groups; no match falls back to ADD
  always_comb begin
    kind_o = ase_pkg::K_ADD;
    hit    = 1'b1;
    case (top11)
      11'h458, 11'h459: kind_o = ase_pkg::K_ADD;
      11'h558, 11'h559: kind_o = ase_pkg::K_ADDS;
      11'h450: kind_o = ase_pkg::K_AND;
      11'h750: kind_o = ase_pkg::K_ANDS;
      11'h6B0: kind_o = ase_pkg::K_BR;
      11'h650: kind_o = ase_pkg::K_EOR;
      11'h4D8: begin
        if (fld == 6'h1F) kind_o = ase_pkg::K_MUL;
        else hit = 1'b0;
      end
      11'h550: kind_o = ase_pkg::K_ORR;
      11'h4D6: kind_o = (fld == 6'd3) ? ase_pkg::K_SDIV : ase_pkg::K_UDIV;
      11'h658, 11'h659: kind_o = ase_pkg::K_SUB;
      11'h758, 11'h759: kind_o = ase_pkg::K_SUBS;
      11'h69A, 11'h69B: kind_o = (fld != 6'h3F) ? ase_pkg::K_LSL : ase_pkg::K_LSR;
      11'h6A2: kind_o = ase_pkg::K_HLT;
      default: hit = 1'b0;
    endcase
    if (!hit) begin
      hit = 1'b1;
      case (top10)
        10'h244: kind_o = ase_pkg::K_ADDI;
        10'h2C4: kind_o = ase_pkg::K_ADDIS;
        10'h344: kind_o = ase_pkg::K_SUBI;
        10'h3C4: kind_o = ase_pkg::K_SUBIS;
        default: hit = 1'b0;
      endcase
    end
    if (!hit) begin
      hit = 1'b1;
      case (top11)
        11'h7C2: kind_o = ase_pkg::K_LDUR;
        11'h7C0: kind_o = ase_pkg::K_STUR;
        11'h1C2: kind_o = ase_pkg::K_LDURB;
        11'h3C2: kind_o = ase_pkg::K_LDURH;
        11'h1C0: kind_o = ase_pkg::K_STURB;
        11'h3C0: kind_o = ase_pkg::K_STURH;
        11'h5C0: kind_o = ase_pkg::K_STURW;
        default: hit = 1'b0;
      endcase
    end
    if (!hit) begin
      hit = 1'b1;
      case (top6)
        6'h05: kind_o = ase_pkg::K_B;
        6'h25: kind_o = ase_pkg::K_BL;
        default: hit = 1'b0;
      endcase
    end
    if (!hit) begin
      hit = 1'b1;
      case (top8)
        8'hB5: kind_o = ase_pkg::K_CBNZ;
        8'hB4: kind_o = ase_pkg::K_CBZ;
        8'h54: begin
          if (cond inside {ase_pkg::COND_EQ, ase_pkg::COND_NE, ase_pkg::COND_GE,
                           ase_pkg::COND_LT, ase_pkg::COND_GT, ase_pkg::COND_LE})
            kind_o = ase_pkg::K_BCOND;
          else hit = 1'b0;
        end
        default: hit = 1'b0;
      endcase
    end
    if (!hit && top9 == 9'h1A5) kind_o = ase_pkg::K_MOVZ;
  end

endmodule

[rtl/ase_queue.sv]
// Two-entry item queue between the front end and the execute back end.
`timescale 1ns / 1ps
module ase_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ase_pkg::item_t item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output ase_pkg::item_t item_o
);

  ase_pkg::item_t slot_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = slot_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wp_q] <= item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      if (push_i && !pop_i) cnt_q <= cnt_q + 2'd1;
      else if (!push_i && pop_i) cnt_q <= cnt_q - 2'd1;
    end
  end

endmodule

[rtl/ase_div.sv]
// Radix-2 restoring 64-bit divider, signed or unsigned, one quotient bit a cycle.
`timescale 1ns / 1ps
module ase_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        sgn_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic        done_o,
  output logic [63:0] q_o
);

  logic        busy_q, done_q, neg_q, zero_q;
  logic [5:0]  cnt_q;
  logic [63:0] rem_q, quo_q, dv_q;
  logic [63:0] ma, mb;
  logic [64:0] rs, diff;

  assign ma   = (sgn_i && a_i[63]) ? (64'd0 - a_i) : a_i;
  assign mb   = (sgn_i && b_i[63]) ? (64'd0 - b_i) : b_i;
  assign rs   = {rem_q, quo_q[63]};
  assign diff = rs - {1'b0, dv_q};

  assign done_o = done_q;
  assign q_o    = zero_q ? 64'd0 : (neg_q ? (64'd0 - quo_q) : quo_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 6'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      zero_q <= (b_i == 64'd0);
      neg_q  <= sgn_i & (a_i[63] ^ b_i[63]);
      rem_q  <= 64'd0;
      quo_q  <= ma;
      dv_q   <= mb;
    end else if (busy_q) begin
      rem_q <= diff[64] ? rs[63:0] : diff[63:0];
      quo_q <= {quo_q[62:0], ~diff[64]};
    end
  end

endmodule

[rtl/ase_back.sv]
// Execute back end: register file, flags, pc, data memory and the sequencer.
`timescale 1ns / 1ps
module ase_back #(
  parameter int DMEM_WORDS = 1024
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic           cfg_index_i,
  input  logic [31:0]    cfg_wdata_i,
  input  logic           q_valid_i,
  input  ase_pkg::item_t item_i,
  output logic           pop_o,
  output logic           clearing_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [63:0]    next_pc_o,
  output logic           halted_o,
  output logic           reg_written_o,
  output logic [4:0]     reg_index_o,
  output logic [63:0]    reg_value_o,
  output logic [3:0]     flags_nzcv_o,
  output logic           mem_written_o
);

  localparam int AW = $clog2(DMEM_WORDS);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD, S_EXEC, S_MUL, S_DIV, S_MADR, S_LDA, S_LDD, S_ST, S_WB
  } state_e;

  state_e         state_q;
  ase_pkg::item_t it_q;
  logic [63:0] a_q, b_q, t_q, res_q, npc_q, pc_q, boff_q, p_q;
  logic [31:0] cross_q, db_q;
  logic [4:0]  rd_q;
  logic [3:0]  flags_q;
  logic        wr_q, halt_q, mw_q, inr_q;
  logic [2:0]  k_q, nlast_q;
  logic [1:0]  lane_q, mstep_q;
  logic [AW-1:0] clr_q;

  // register file: two registered read ports, valid bits give the zero reset
  logic [63:0] rf_mem [32];
  logic [31:0] rf_vld_q;
  logic [63:0] rda_q, rdb_q, rda_eff, rdb_eff;
  logic        va_q, vb_q;
  logic [4:0]  rf_ra, rf_rb;
  logic        rf_we;

  assign rf_ra   = (state_q == S_IDLE) ? item_i.instruction[9:5] : it_q.instruction[4:0];
  assign rf_rb   = item_i.instruction[20:16];
  assign rf_we   = (state_q == S_WB) && wr_q;
  assign rda_eff = va_q ? rda_q : 64'd0;
  assign rdb_eff = vb_q ? rdb_q : 64'd0;

  always_ff @(posedge clk_i) begin
    if (rf_we) rf_mem[rd_q] <= res_q;
    rda_q <= rf_mem[rf_ra];
    rdb_q <= rf_mem[rf_rb];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_vld_q <= '0;
      va_q     <= 1'b0;
      vb_q     <= 1'b0;
    end else begin
      if (rf_we) rf_vld_q[rd_q] <= 1'b1;
      va_q <= rf_vld_q[rf_ra];
      vb_q <= rf_vld_q[rf_rb];
    end
  end

  // data memory with byte lanes
  logic [31:0]   dmem [DMEM_WORDS];
  logic [31:0]   dm_rd_q, dm_wd;
  logic [AW-1:0] dm_wa;
  logic [3:0]    dm_be;
  logic          dm_we;
  logic [63:0]   byte_off;
  logic          byte_inr;
  logic [AW-1:0] byte_wi;
  logic [1:0]    byte_lane;
  logic [7:0]    st_byte;
  logic [31:0]   pidx_w;
  logic          pidx_inr;

  assign byte_off  = boff_q + 64'(k_q);
  assign byte_inr  = (byte_off[63:2] < 62'(DMEM_WORDS));
  assign byte_wi   = byte_off[AW+1:2];
  assign byte_lane = byte_off[1:0];
  assign st_byte   = t_q[8*k_q +: 8];
  assign pidx_w    = 32'(it_q.preload_index);
  assign pidx_inr  = (pidx_w < 32'(DMEM_WORDS));

  always_comb begin
    dm_we = 1'b0;
    dm_wa = byte_wi;
    dm_be = 4'h0;
    dm_wd = {4{st_byte}};
    case (state_q)
      S_CLEAR: begin
        dm_we = 1'b1;
        dm_wa = clr_q;
        dm_be = 4'hF;
        dm_wd = 32'd0;
      end
      S_EXEC: begin
        if (it_q.opcode == ase_pkg::OP_PRELOAD && pidx_inr) begin
          dm_we = 1'b1;
          dm_wa = pidx_w[AW-1:0];
          dm_be = 4'hF;
          dm_wd = it_q.preload_value;
        end
      end
      S_ST: begin
        dm_we = byte_inr;
        dm_be = 4'(1) << byte_lane;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (dm_we) begin
      for (int l = 0; l < 4; l++) begin
        if (dm_be[l]) dmem[dm_wa][8*l +: 8] <= dm_wd[8*l +: 8];
      end
    end
    dm_rd_q <= dmem[byte_wi];
  end

  // multiplier: one 32x32 product per step
  logic [31:0] mx, my;
  logic [63:0] mprod;
  assign mx    = (mstep_q == 2'd2) ? a_q[63:32] : a_q[31:0];
  assign my    = (mstep_q == 2'd1) ? b_q[63:32] : b_q[31:0];
  assign mprod = 64'(mx) * 64'(my);

  // divider
  logic        div_start, div_done;
  logic [63:0] div_q;
  logic        exec_live;
  assign exec_live = (it_q.opcode == ase_pkg::OP_EXEC) && !halt_q;
  assign div_start = (state_q == S_EXEC) && exec_live &&
                     (it_q.kind == ase_pkg::K_SDIV || it_q.kind == ase_pkg::K_UDIV);

  ase_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .sgn_i  (it_q.kind == ase_pkg::K_SDIV),
    .a_i    (a_q),
    .b_i    (b_q),
    .done_o (div_done),
    .q_o    (div_q)
  );

  function automatic logic [63:0] shift_op(input logic [63:0] v, input logic [1:0] ty,
                                           input logic [5:0] amt);
    logic [127:0] rr;
    rr = {v, v} >> amt;
    case (ty)
      2'd0:    return v << amt;
      2'd1:    return v >> amt;
      2'd2:    return $signed(v) >>> amt;
      default: return rr[63:0];
    endcase
  endfunction

  // combinational execute datapath
  logic [31:0] w;
  logic [63:0] off9, imm12, sh_b, op2, op2x, bdisp, cdisp, movz_v;
  logic [64:0] sum;
  logic        is_sub, is_imm, sum_v, take;
  logic        nf, zf, vf;

  assign w      = it_q.instruction;
  assign off9   = {{55{w[20]}}, w[20:12]};
  assign imm12  = 64'(w[21:10]);
  assign sh_b   = shift_op(b_q, w[23:22], w[15:10]);
  assign bdisp  = {{36{w[25]}}, w[25:0], 2'b00};
  assign cdisp  = {{43{w[23]}}, w[23:5], 2'b00};
  assign movz_v = 64'(w[20:5]) << {w[22:21], 4'b0000};
  assign is_imm = (it_q.kind == ase_pkg::K_ADDI) || (it_q.kind == ase_pkg::K_ADDIS) ||
                  (it_q.kind == ase_pkg::K_SUBI) || (it_q.kind == ase_pkg::K_SUBIS);
  assign is_sub = (it_q.kind == ase_pkg::K_SUB) || (it_q.kind == ase_pkg::K_SUBS) ||
                  (it_q.kind == ase_pkg::K_SUBI) || (it_q.kind == ase_pkg::K_SUBIS);
  assign op2    = is_imm ? imm12 : b_q;
  assign op2x   = is_sub ? ~op2 : op2;
  assign sum    = {1'b0, a_q} + {1'b0, op2x} + 65'(is_sub);
  assign sum_v  = (a_q[63] == op2x[63]) && (sum[63] != a_q[63]);
  assign nf     = flags_q[3];
  assign zf     = flags_q[2];
  assign vf     = flags_q[0];

  always_comb begin
    case (w[4:0])
      ase_pkg::COND_EQ: take = zf;
      ase_pkg::COND_NE: take = !zf;
      ase_pkg::COND_GE: take = (nf == vf);
      ase_pkg::COND_LT: take = (nf != vf);
      ase_pkg::COND_GT: take = !zf && (nf == vf);
      default:          take = !(!zf && (nf == vf));
    endcase
    if (it_q.kind == ase_pkg::K_CBNZ) take = (rda_eff != 64'd0);
    else if (it_q.kind == ase_pkg::K_CBZ) take = (rda_eff == 64'd0);
  end

  assign pop_o      = (state_q == S_IDLE) && q_valid_i && !out_valid_o;
  assign clearing_o = (state_q == S_CLEAR);

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_CLEAR;
      clr_q         <= '0;
      pc_q          <= 64'(ase_pkg::START_PC_RST);
      db_q          <= ase_pkg::DATA_BASE_RST;
      flags_q       <= 4'd0;
      halt_q        <= 1'b0;
      out_valid_o   <= 1'b0;
      next_pc_o     <= 64'd0;
      halted_o      <= 1'b0;
      reg_written_o <= 1'b0;
      reg_index_o   <= 5'd0;
      reg_value_o   <= 64'd0;
      flags_nzcv_o  <= 4'd0;
      mem_written_o <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == ase_pkg::CFG_START_PC) pc_q <= 64'(cfg_wdata_i);
        else db_q <= cfg_wdata_i;
      end
      if (out_valid_o && !out_stall_i) out_valid_o <= 1'b0;
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == AW'(DMEM_WORDS - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (pop_o) begin
            it_q    <= item_i;
            state_q <= S_RD;
          end
        end
        S_RD: begin
          a_q     <= rda_eff;
          b_q     <= rdb_eff;
          state_q <= S_EXEC;
        end
        S_EXEC: begin
          t_q     <= rda_eff;
          res_q   <= 64'd0;
          wr_q    <= 1'b0;
          mw_q    <= 1'b0;
          rd_q    <= w[4:0];
          npc_q   <= pc_q;
          state_q <= S_WB;
          k_q     <= 3'd0;
          mstep_q <= 2'd0;
          if (exec_live) begin
            npc_q <= pc_q + 64'd4;
            case (it_q.kind)
              ase_pkg::K_ADD, ase_pkg::K_SUB, ase_pkg::K_ADDI, ase_pkg::K_SUBI: begin
                res_q <= sum[63:0];
                wr_q  <= 1'b1;
              end
              ase_pkg::K_ADDS, ase_pkg::K_ADDIS, ase_pkg::K_SUBS, ase_pkg::K_SUBIS: begin
                res_q   <= sum[63:0];
                flags_q <= {sum[63], sum[63:0] == 64'd0, sum[64], sum_v};
                wr_q    <= !is_sub || (w[4:0] != ase_pkg::ZR_REG);
              end
              ase_pkg::K_AND: begin
                res_q <= a_q & sh_b;
                wr_q  <= 1'b1;
              end
              ase_pkg::K_ANDS: begin
                res_q   <= a_q & sh_b;
                flags_q <= {(a_q[63] & sh_b[63]), (a_q & sh_b) == 64'd0, 2'b00};
                wr_q    <= 1'b1;
              end
              ase_pkg::K_EOR: begin
                res_q <= a_q ^ sh_b;
                wr_q  <= 1'b1;
              end
              ase_pkg::K_ORR: begin
                res_q <= a_q | sh_b;
                wr_q  <= 1'b1;
              end
              ase_pkg::K_LSL: begin
                res_q <= a_q << (6'd0 - w[21:16]);
                wr_q  <= 1'b1;
              end
              ase_pkg::K_LSR: begin
                res_q <= a_q >> w[21:16];
                wr_q  <= 1'b1;
              end
              ase_pkg::K_MOVZ: begin
                res_q <= movz_v;
                wr_q  <= 1'b1;
              end
              ase_pkg::K_MUL: begin
                wr_q    <= 1'b1;
                state_q <= S_MUL;
              end
              ase_pkg::K_SDIV, ase_pkg::K_UDIV: begin
                wr_q    <= 1'b1;
                state_q <= S_DIV;
              end
              ase_pkg::K_LDUR, ase_pkg::K_LDURB, ase_pkg::K_LDURH: begin
                wr_q    <= 1'b1;
                boff_q  <= a_q + off9;
                nlast_q <= (it_q.kind == ase_pkg::K_LDUR) ? 3'd7 :
                           (it_q.kind == ase_pkg::K_LDURH) ? 3'd1 : 3'd0;
                state_q <= S_MADR;
              end
              ase_pkg::K_STUR, ase_pkg::K_STURW, ase_pkg::K_STURH, ase_pkg::K_STURB: begin
                boff_q  <= a_q + off9;
                nlast_q <= (it_q.kind == ase_pkg::K_STUR)  ? 3'd7 :
                           (it_q.kind == ase_pkg::K_STURW) ? 3'd3 :
                           (it_q.kind == ase_pkg::K_STURH) ? 3'd1 : 3'd0;
                state_q <= S_MADR;
              end
              ase_pkg::K_BR: npc_q <= a_q;
              ase_pkg::K_B: npc_q <= pc_q + bdisp;
              ase_pkg::K_BL: begin
                npc_q <= pc_q + bdisp;
                res_q <= pc_q + 64'd4;
                rd_q  <= ase_pkg::LINK_REG;
                wr_q  <= 1'b1;
              end
              ase_pkg::K_CBNZ, ase_pkg::K_CBZ, ase_pkg::K_BCOND: begin
                if (take) npc_q <= pc_q + cdisp;
              end
              default: halt_q <= 1'b1;
            endcase
          end
        end
        S_MUL: begin
          mstep_q <= mstep_q + 2'd1;
          case (mstep_q)
            2'd0: p_q <= mprod;
            2'd1: cross_q <= mprod[31:0];
            2'd2: cross_q <= cross_q + mprod[31:0];
            default: begin
              res_q   <= p_q + {cross_q, 32'd0};
              state_q <= S_WB;
            end
          endcase
        end
        S_DIV: begin
          if (div_done) begin
            res_q   <= div_q;
            state_q <= S_WB;
          end
        end
        S_MADR: begin
          boff_q  <= boff_q - 64'(db_q);
          state_q <= wr_q ? S_LDA : S_ST;
        end
        S_LDA: begin
          inr_q   <= byte_inr;
          lane_q  <= byte_lane;
          state_q <= S_LDD;
        end
        S_LDD: begin
          if (inr_q) res_q[8*k_q +: 8] <= dm_rd_q[8*lane_q +: 8];
          if (k_q == nlast_q) state_q <= S_WB;
          else begin
            k_q     <= k_q + 3'd1;
            state_q <= S_LDA;
          end
        end
        S_ST: begin
          if (byte_inr) mw_q <= 1'b1;
          if (k_q == nlast_q) state_q <= S_WB;
          else k_q <= k_q + 3'd1;
        end
        S_WB: begin
          pc_q          <= npc_q;
          out_valid_o   <= 1'b1;
          next_pc_o     <= npc_q;
          halted_o      <= halt_q;
          reg_written_o <= wr_q;
          reg_index_o   <= wr_q ? rd_q : 5'd0;
          reg_value_o   <= wr_q ? res_q : 64'd0;
          flags_nzcv_o  <= flags_q;
          mem_written_o <= mw_q;
          state_q       <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/arm64_subset_execute_core.sv]
// Top level of the A64 subset execute core: front end, item queue, back end.
// Path from queue pop to result: S_RD, S_EXEC and S_WB for ALU, branch, preload and
// halted items; MUL adds S_MUL and SDIV/UDIV add S_DIV (one quotient bit per cycle);
// loads add S_MADR and S_LDA/S_LDD per byte; stores S_MADR and S_ST (one byte a cycle).
// One item in the back end at a time; the queue holds two more.
// Reset: async active low; a clearing pass then zeroes every word of data memory.
`timescale 1ns / 1ps
module arm64_subset_execute_core #(
  parameter int DMEM_WORDS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        opcode_i,
  input  logic [31:0] instruction_i,
  input  logic [9:0]  preload_index_i,
  input  logic [31:0] preload_value_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] next_pc_o,
  output logic        halted_o,
  output logic        reg_written_o,
  output logic [4:0]  reg_index_o,
  output logic [63:0] reg_value_o,
  output logic [3:0]  flags_nzcv_o,
  output logic        mem_written_o,
  // configuration
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_wdata_i
);

  ase_pkg::kind_e kind;
  ase_pkg::item_t in_item, q_item;
  logic           q_full, q_valid, q_pop, clearing, push;

  // classify the word on the way in so the back end starts from a kind
  ase_front u_front (
    .instruction_i(instruction_i),
    .kind_o       (kind)
  );

  assign in_item.opcode        = opcode_i;
  assign in_item.instruction   = instruction_i;
  assign in_item.preload_index = preload_index_i;
  assign in_item.preload_value = preload_value_i;
  assign in_item.kind          = kind;

  // no item taken while the data memory clearing pass runs
  assign in_stall_o = q_full | clearing;
  assign push       = in_valid_i & ~in_stall_o;

  ase_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (in_item),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .item_o (q_item)
  );

  ase_back #(
    .DMEM_WORDS(DMEM_WORDS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .q_valid_i    (q_valid),
    .item_i       (q_item),
    .pop_o        (q_pop),
    .clearing_o   (clearing),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .next_pc_o    (next_pc_o),
    .halted_o     (halted_o),
    .reg_written_o(reg_written_o),
    .reg_index_o  (reg_index_o),
    .reg_value_o  (reg_value_o),
    .flags_nzcv_o (flags_nzcv_o),
    .mem_written_o(mem_written_o)
  );

endmodule

[rtl/ase_checker.sv]
// Port-level checker for the execute core, bound to the top level.
`timescale 1ns / 1ps
module ase_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [63:0] next_pc_o,
  input logic        halted_o,
  input logic        reg_written_o,
  input logic [4:0]  reg_index_o,
  input logic [63:0] reg_value_o,
  input logic        mem_written_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(next_pc_o))
    else $error("stalled result changed");

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_o |=> halted_o)
    else $error("halt flag dropped");

  a_no_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !reg_written_o |-> reg_index_o == 5'd0 && reg_value_o == 64'd0)
    else $error("register fields set without write");

  a_store_no_reg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && mem_written_o |-> !reg_written_o)
    else $error("store also wrote a register");

endmodule

bind arm64_subset_execute_core ase_checker u_chk (.*);

[tb/tb_arm64_subset_execute_core.sv]
// Self-checking testbench for the A64 subset execute core.
`timescale 1ns / 1ps
module tb_arm64_subset_execute_core;
  import ase_pkg::*;

  localparam int DMEM_WORDS = 1024;
  // Instruction encodings (top 11 bits unless noted)
  localparam logic [10:0] E_ADD   = 11'h458;
  localparam logic [10:0] E_ADDS  = 11'h558;
  localparam logic [10:0] E_AND   = 11'h450;
  localparam logic [10:0] E_ANDS  = 11'h750;
  localparam logic [10:0] E_BR    = 11'h6B0;
  localparam logic [10:0] E_EOR   = 11'h650;
  localparam logic [10:0] E_MUL   = 11'h4D8;
  localparam logic [10:0] E_ORR   = 11'h550;
  localparam logic [10:0] E_DIV   = 11'h4D6;
  localparam logic [10:0] E_SUB   = 11'h658;
  localparam logic [10:0] E_SUBS  = 11'h758;
  localparam logic [10:0] E_SHI   = 11'h69A;
  localparam logic [10:0] E_HLT   = 11'h6A2;
  localparam logic [10:0] E_LDUR  = 11'h7C2;
  localparam logic [10:0] E_STUR  = 11'h7C0;
  localparam logic [10:0] E_LDURB = 11'h1C2;
  localparam logic [10:0] E_LDURH = 11'h3C2;
  localparam logic [10:0] E_STURB = 11'h1C0;
  localparam logic [10:0] E_STURH = 11'h3C0;
  localparam logic [10:0] E_STURW = 11'h5C0;
  localparam logic [9:0]  E_ADDI  = 10'h244;
  localparam logic [9:0]  E_ADDIS = 10'h2C4;
  localparam logic [9:0]  E_SUBI  = 10'h344;
  localparam logic [9:0]  E_SUBIS = 10'h3C4;
  localparam logic [5:0]  E_B     = 6'h05;
  localparam logic [5:0]  E_BL    = 6'h25;
  localparam logic [7:0]  E_CBNZ  = 8'hB5;
  localparam logic [7:0]  E_CBZ   = 8'hB4;
  localparam logic [7:0]  E_BCOND = 8'h54;
  localparam logic [8:0]  E_MOVZ  = 9'h1A5;
  localparam logic [5:0]  FLD_MUL = 6'h1F;
  localparam logic [5:0]  FLD_SDIV = 6'h03;
  localparam logic [5:0]  FLD_UDIV = 6'h02;
  localparam logic [5:0]  FLD_LSR = 6'h3F;
  localparam int DRAIN_CYCLES = 80;  // longer than a divide

  typedef struct packed {
    logic [63:0] npc;
    logic        halted;
    logic        wr;
    logic [4:0]  idx;
    logic [63:0] val;
    logic [3:0]  nzcv;
    logic        mw;
  } res_t;

  typedef struct {
    logic        opcode;
    logic [31:0] instr;
    logic [9:0]  pidx;
    logic [31:0] pval;
    logic        typed;
    res_t        exp_r;
  } stim_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        opcode_i = OP_EXEC;
  logic [31:0] instruction_i = '0;
  logic [9:0]  preload_index_i = '0;
  logic [31:0] preload_value_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [63:0] next_pc_o;
  logic        halted_o;
  logic        reg_written_o;
  logic [4:0]  reg_index_o;
  logic [63:0] reg_value_o;
  logic [3:0]  flags_nzcv_o;
  logic        mem_written_o;
  logic        cfg_we_i = 1'b0;
  logic        cfg_index_i = CFG_START_PC;
  logic [31:0] cfg_wdata_i = '0;

  arm64_subset_execute_core #(.DMEM_WORDS(DMEM_WORDS)) DUT (.*);

  // Shadow architectural state
  logic [63:0] gpr[32];
  logic [63:0] cur_pc;
  logic [3:0]  cur_nzcv;
  logic [31:0] dmem[DMEM_WORDS];
  logic        is_halted;
  logic [31:0] cur_start_pc;
  logic [31:0] cur_data_base;

  res_t expected_q[$];
  int   tx_idle_pct, rx_idle_pct;
  int   n_items, n_results, n_mismatch;
  stim_t dir_tab[$];

  initial forever #2 clk_i = ~clk_i;

  // ---------------- encoders ----------------
  function automatic logic [31:0] rrr(logic [10:0] top, logic [4:0] rm, logic [5:0] sh,
                                      logic [4:0] rn, logic [4:0] rd);
    return {top, rm, sh, rn, rd};
  endfunction
  function automatic logic [31:0] imm_op(logic [9:0] top, logic [11:0] imm, logic [4:0] rn,
                                         logic [4:0] rd);
    return {top, imm, rn, rd};
  endfunction
  function automatic logic [31:0] mem_op(logic [10:0] top, logic [8:0] imm9, logic [4:0] rn,
                                         logic [4:0] rt);
    return {top, imm9, 2'b00, rn, rt};
  endfunction
  function automatic logic [31:0] movz(logic [1:0] hw, logic [15:0] imm, logic [4:0] rd);
    return {E_MOVZ, hw, imm, rd};
  endfunction
  function automatic logic [31:0] shimm(logic [5:0] immr, logic [5:0] imms, logic [4:0] rn,
                                        logic [4:0] rd);
    return {E_SHI[10:1], immr, imms, rn, rd};
  endfunction
  function automatic logic [31:0] cbr(logic [7:0] top, logic [18:0] imm19, logic [4:0] rt);
    return {top, imm19, rt};
  endfunction

  function automatic stim_t ex(logic [31:0] w);
    stim_t s;
    s = '{OP_EXEC, w, 10'($urandom), $urandom, 1'b0, '0};
    return s;
  endfunction
  function automatic stim_t pre(logic [9:0] idx, logic [31:0] val);
    stim_t s;
    s = '{OP_PRELOAD, $urandom, idx, val, 1'b0, '0};
    return s;
  endfunction
  function automatic stim_t ex_typed(logic [31:0] w, res_t r);
    stim_t s;
    s = ex(w);
    s.typed = 1'b1;
    s.exp_r = r;
    return s;
  endfunction

  // ---------------- predictor ----------------
  function automatic kind_e decode_kind(logic [31:0] w);
    logic [10:0] top = w[31:21];
    logic [5:0]  fld = w[15:10];
    case (top)
      E_ADD, E_ADD | 11'h1:   return K_ADD;
      E_ADDS, E_ADDS | 11'h1: return K_ADDS;
      E_AND:                  return K_AND;
      E_ANDS:                 return K_ANDS;
      E_BR:                   return K_BR;
      E_EOR:                  return K_EOR;
      E_MUL:                  if (fld == FLD_MUL) return K_MUL;
      E_ORR:                  return K_ORR;
      E_DIV:                  return (fld == FLD_SDIV) ? K_SDIV : K_UDIV;
      E_SUB, E_SUB | 11'h1:   return K_SUB;
      E_SUBS, E_SUBS | 11'h1: return K_SUBS;
      E_SHI, E_SHI | 11'h1:   return (fld != FLD_LSR) ? K_LSL : K_LSR;
      E_HLT:                  return K_HLT;
      default: ;
    endcase
    case (w[31:22])
      E_ADDI:  return K_ADDI;
      E_ADDIS: return K_ADDIS;
      E_SUBI:  return K_SUBI;
      E_SUBIS: return K_SUBIS;
      default: ;
    endcase
    case (top)
      E_LDUR:  return K_LDUR;
      E_STUR:  return K_STUR;
      E_LDURB: return K_LDURB;
      E_LDURH: return K_LDURH;
      E_STURB: return K_STURB;
      E_STURH: return K_STURH;
      E_STURW: return K_STURW;
      default: ;
    endcase
    if (w[31:26] == E_B) return K_B;
    if (w[31:26] == E_BL) return K_BL;
    if (w[31:24] == E_CBNZ) return K_CBNZ;
    if (w[31:24] == E_CBZ) return K_CBZ;
    if (w[31:24] == E_BCOND && w[4:0] inside {COND_EQ, COND_NE, COND_GE, COND_LT,
                                              COND_GT, COND_LE}) return K_BCOND;
    if (w[31:23] == E_MOVZ) return K_MOVZ;
    return K_ADD;
  endfunction

  function automatic logic [63:0] shifted(logic [63:0] x, logic [1:0] st, logic [5:0] amt);
    case (st)
      2'd0: return x << amt;
      2'd1: return x >> amt;
      2'd2: return $signed(x) >>> amt;
      default: return (amt == 0) ? x : ((x >> amt) | (x << (7'd64 - amt)));
    endcase
  endfunction

  function automatic logic [3:0] nz_of(logic [63:0] r);
    return {r[63], r == 64'd0, 2'b00};
  endfunction
  function automatic logic [3:0] add_nzcv(logic [63:0] x, logic [63:0] y);
    logic [64:0] s = {1'b0, x} + {1'b0, y};
    return nz_of(s[63:0]) | {2'b00, s[64], (~(x[63] ^ y[63])) & (x[63] ^ s[63])};
  endfunction
  function automatic logic [3:0] sub_nzcv(logic [63:0] x, logic [63:0] y);
    logic [63:0] r = x - y;
    return nz_of(r) | {2'b00, x >= y, (x[63] ^ y[63]) & (x[63] ^ r[63])};
  endfunction

  function automatic logic [63:0] mem_load(logic [63:0] addr, int nb);
    logic [63:0] val = '0;
    logic [63:0] off;
    for (int k = 0; k < nb; k++) begin
      off = addr + 64'(k) - {32'd0, cur_data_base};
      if ((off >> 2) < DMEM_WORDS)
        val[8*k +: 8] = dmem[off >> 2][8*off[1:0] +: 8];
    end
    return val;
  endfunction

  function automatic logic mem_store(logic [63:0] addr, logic [63:0] val, int nb);
    logic any = 1'b0;
    logic [63:0] off;
    for (int k = 0; k < nb; k++) begin
      off = addr + 64'(k) - {32'd0, cur_data_base};
      if ((off >> 2) < DMEM_WORDS) begin
        dmem[off >> 2][8*off[1:0] +: 8] = val[8*k +: 8];
        any = 1'b1;
      end
    end
    return any;
  endfunction

  // Advances the shadow state by one item and returns the result it must produce.
  function automatic res_t execute_item(stim_t s);
    logic [31:0] w = s.instr;
    logic [4:0]  rd = w[4:0];
    logic [63:0] a = gpr[w[9:5]];
    logic [63:0] b = gpr[w[20:16]];
    logic [5:0]  amt = w[15:10];
    logic [5:0]  immr = w[21:16];
    logic [63:0] imm12 = {52'd0, w[21:10]};
    logic [63:0] addr = a + {{55{w[20]}}, w[20:12]};
    logic [63:0] npc = cur_pc + 64'd4;
    logic [63:0] res = '0;
    logic [63:0] d, ma, mb, q;
    logic        wr = 1'b0, mw = 1'b0, take;
    logic        fn = cur_nzcv[3], fz = cur_nzcv[2], fv = cur_nzcv[0];
    kind_e       k;
    res_t        r;
    if (s.opcode == OP_PRELOAD) begin
      dmem[s.pidx] = s.pval;
      npc = cur_pc;
    end else if (is_halted) begin
      npc = cur_pc;
    end else begin
      k = decode_kind(w);
      case (k)
        K_ADD:  begin res = a + b; wr = 1; end
        K_ADDS: begin res = a + b; cur_nzcv = add_nzcv(a, b); wr = 1; end
        K_SUB:  begin res = a - b; wr = 1; end
        K_SUBS: begin res = a - b; cur_nzcv = sub_nzcv(a, b); wr = (rd != ZR_REG); end
        K_ADDI: begin res = a + imm12; wr = 1; end
        K_ADDIS: begin res = a + imm12; cur_nzcv = add_nzcv(a, imm12); wr = 1; end
        K_SUBI: begin res = a - imm12; wr = 1; end
        K_SUBIS: begin
          res = a - imm12; cur_nzcv = sub_nzcv(a, imm12); wr = (rd != ZR_REG);
        end
        K_AND:  begin res = a & shifted(b, w[23:22], amt); wr = 1; end
        K_ANDS: begin
          res = a & shifted(b, w[23:22], amt); cur_nzcv = nz_of(res); wr = 1;
        end
        K_EOR:  begin res = a ^ shifted(b, w[23:22], amt); wr = 1; end
        K_ORR:  begin res = a | shifted(b, w[23:22], amt); wr = 1; end
        K_MUL:  begin res = a * b; wr = 1; end
        K_UDIV: begin res = (b != 0) ? a / b : 64'd0; wr = 1; end
        K_SDIV: begin
          if (b != 0) begin
            ma = a[63] ? -a : a;
            mb = b[63] ? -b : b;
            q = ma / mb;
            res = (a[63] ^ b[63]) ? -q : q;
          end
          wr = 1;
        end
        K_LSL:  begin res = a << (6'd0 - immr); wr = 1; end
        K_LSR:  begin res = a >> immr; wr = 1; end
        K_MOVZ: begin res = {48'd0, w[20:5]} << (w[22:21] * 16); wr = 1; end
        K_LDUR:  begin res = mem_load(addr, 8); wr = 1; end
        K_LDURB: begin res = mem_load(addr, 1); wr = 1; end
        K_LDURH: begin res = mem_load(addr, 2); wr = 1; end
        K_STUR:  mw = mem_store(addr, gpr[rd], 8);
        K_STURW: mw = mem_store(addr, gpr[rd], 4);
        K_STURH: mw = mem_store(addr, gpr[rd], 2);
        K_STURB: mw = mem_store(addr, gpr[rd], 1);
        K_BR:   npc = a;
        K_B, K_BL: begin
          d = {{36{w[25]}}, w[25:0], 2'b00};
          if (k == K_BL) begin
            rd = LINK_REG;
            res = cur_pc + 64'd4;
            wr = 1;
          end
          npc = cur_pc + d;
        end
        K_CBNZ, K_CBZ, K_BCOND: begin
          d = {{43{w[23]}}, w[23:5], 2'b00};
          if (k == K_CBNZ) take = (gpr[rd] != 0);
          else if (k == K_CBZ) take = (gpr[rd] == 0);
          else case (w[4:0])
            COND_EQ: take = fz;
            COND_NE: take = !fz;
            COND_GE: take = (fn == fv);
            COND_LT: take = (fn != fv);
            COND_GT: take = !fz && (fn == fv);
            default: take = !(!fz && (fn == fv));
          endcase
          if (take) npc = cur_pc + d;
        end
        default: is_halted = 1'b1;  // HLT
      endcase
      if (wr) gpr[rd] = res;
      cur_pc = npc;
    end
    r.npc = npc;
    r.halted = is_halted;
    r.wr = wr;
    r.idx = wr ? rd : 5'd0;
    r.val = wr ? res : 64'd0;
    r.nzcv = cur_nzcv;
    r.mw = mw;
    return r;
  endfunction

  // ---------------- stimulus ----------------
  function automatic logic [4:0] pick_reg();
    return ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 7));
  endfunction

  // One random instruction of a random kind with random fields
  function automatic logic [31:0] rand_instr();
    logic [4:0]  rd = pick_reg(), rn = pick_reg(), rm = pick_reg();
    logic [31:0] x = $urandom;
    logic [4:0]  conds[6] = '{COND_EQ, COND_NE, COND_GE, COND_LT, COND_GT, COND_LE};
    kind_e k = kind_e'($urandom_range(0, 31));
    case (k)
      K_ADD:   return rrr(E_ADD | 11'(x[0]), rm, x[15:10], rn, rd);
      K_ADDS:  return rrr(E_ADDS | 11'(x[0]), rm, x[15:10], rn, rd);
      K_SUB:   return rrr(E_SUB | 11'(x[0]), rm, x[15:10], rn, rd);
      K_SUBS:  return rrr(E_SUBS | 11'(x[0]), rm, x[15:10], rn, x[1] ? ZR_REG : rd);
      K_AND:   return rrr(E_AND, rm, x[15:10], rn, rd);
      K_ANDS:  return rrr(E_ANDS, rm, x[15:10], rn, rd);
      K_EOR:   return rrr(E_EOR, rm, x[15:10], rn, rd);
      K_ORR:   return rrr(E_ORR, rm, x[15:10], rn, rd);
      K_MUL:   return rrr(E_MUL, rm, FLD_MUL, rn, rd);
      K_SDIV:  return rrr(E_DIV, rm, FLD_SDIV, rn, rd);
      K_UDIV:  return rrr(E_DIV, rm, x[1] ? FLD_UDIV : x[15:10], rn, rd);
      K_LSL:   return shimm(x[21:16], x[15:10] & 6'h3E, rn, rd);
      K_LSR:   return shimm(x[21:16], FLD_LSR, rn, rd);
      K_ADDI:  return imm_op(E_ADDI, x[21:10], rn, rd);
      K_ADDIS: return imm_op(E_ADDIS, x[21:10], rn, rd);
      K_SUBI:  return imm_op(E_SUBI, x[21:10], rn, rd);
      K_SUBIS: return imm_op(E_SUBIS, x[21:10], rn, x[1] ? ZR_REG : rd);
      K_LDUR:  return mem_op(E_LDUR, x[20:12], rn, rd);
      K_STUR:  return mem_op(E_STUR, x[20:12], rn, rd);
      K_LDURB: return mem_op(E_LDURB, x[20:12], rn, rd);
      K_LDURH: return mem_op(E_LDURH, x[20:12], rn, rd);
      K_STURB: return mem_op(E_STURB, x[20:12], rn, rd);
      K_STURH: return mem_op(E_STURH, x[20:12], rn, rd);
      K_STURW: return mem_op(E_STURW, x[20:12], rn, rd);
      K_BR:    return rrr(E_BR, rm, x[15:10], rn, rd);
      K_B:     return {E_B, x[25:0]};
      K_BL:    return {E_BL, x[25:0]};
      K_CBNZ:  return cbr(E_CBNZ, x[23:5], rd);
      K_CBZ:   return cbr(E_CBZ, x[23:5], rd);
      K_BCOND: return cbr(E_BCOND, x[23:5], x[1] ? conds[$urandom_range(0, 5)] : x[4:0]);
      K_MOVZ:  return movz(x[22:21], x[20:5], rd);
      default: return movz(x[22:21], x[20:5], rd);  // HLT kept for the end of the run
    endcase
  endfunction

  task automatic send_item(stim_t s);
    res_t r;
    if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    opcode_i        <= s.opcode;
    instruction_i   <= s.instr;
    preload_index_i <= s.pidx;
    preload_value_i <= s.pval;
    do @(posedge clk_i); while (in_stall_o);
    r = execute_item(s);
    expected_q.push_back(s.typed ? s.exp_r : r);
    n_items++;
  endtask

  // Stops sending until the core has emptied, then writes one register
  task automatic drain_and_config(logic idx, logic [31:0] val);
    in_valid_i <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_START_PC) begin
      cur_start_pc = val;
      cur_pc = {32'd0, val};
    end else begin
      cur_data_base = val;
    end
  endtask

  // Random body: preloads, noise words, single instructions and memory
  // sequences that point a base register into the data window.
  task automatic random_items(int count);
    logic [4:0]  rb, rt;
    logic [31:0] base;
    int done = 0;
    while (done < count) begin
      case ($urandom_range(0, 9))
        0: begin send_item(pre(10'($urandom), $urandom)); done++; end
        1: begin send_item(ex($urandom)); done++; end
        2, 3, 4: begin
          rb = 5'($urandom_range(8, 15));
          rt = 5'($urandom_range(16, 23));
          base = cur_data_base;
          send_item(ex(movz(2'd0, base[15:0], rt)));
          send_item(ex(movz(2'd1, base[31:16], rb)));
          send_item(ex(rrr(E_ORR, rt, 6'd0, rb, rb)));
          send_item(ex(imm_op(E_ADDI, 12'($urandom_range(0, 4095)), rb, rb)));
          done += 4;
          repeat ($urandom_range(1, 4)) begin
            case ($urandom_range(0, 6))
              0: send_item(ex(mem_op(E_LDUR, 9'($urandom), rb, pick_reg())));
              1: send_item(ex(mem_op(E_LDURB, 9'($urandom), rb, pick_reg())));
              2: send_item(ex(mem_op(E_LDURH, 9'($urandom), rb, pick_reg())));
              3: send_item(ex(mem_op(E_STUR, 9'($urandom), rb, pick_reg())));
              4: send_item(ex(mem_op(E_STURW, 9'($urandom), rb, pick_reg())));
              5: send_item(ex(mem_op(E_STURH, 9'($urandom), rb, pick_reg())));
              default: send_item(ex(mem_op(E_STURB, 9'($urandom), rb, pick_reg())));
            endcase
            done++;
          end
        end
        default: begin send_item(ex(rand_instr())); done++; end
      endcase
    end
  endtask

  // ---------------- result checking ----------------
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < rx_idle_pct);
  end

  always @(posedge clk_i) begin
    res_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{next_pc_o, halted_o, reg_written_o, reg_index_o, reg_value_o,
              flags_nzcv_o, mem_written_o};
      n_results++;
      if (expected_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("%0t: unexpected result %p", $realtime, got);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          n_mismatch++;
          if (n_mismatch <= 10) begin
            $display("%0t: result %0d mismatch", $realtime, n_results);
            $display("  expected pc=%h h=%b w=%b x%0d=%h nzcv=%b mw=%b", want.npc,
                     want.halted, want.wr, want.idx, want.val, want.nzcv, want.mw);
            $display("  actual   pc=%h h=%b w=%b x%0d=%h nzcv=%b mw=%b", got.npc,
                     got.halted, got.wr, got.idx, got.val, got.nzcv, got.mw);
          end
        end
      end
    end
  end

  // Watchdog
  initial begin
    #8_000_000;
    $display("FAIL arm64_subset_execute_core");
    $finish;
  end

  // ---------------- main sequence ----------------
  initial begin
    foreach (gpr[i]) gpr[i] = '0;
    foreach (dmem[i]) dmem[i] = '0;
    cur_start_pc = START_PC_RST;
    cur_data_base = DATA_BASE_RST;
    cur_pc = {32'd0, START_PC_RST};
    cur_nzcv = '0;
    is_halted = 1'b0;
    n_items = 0;
    n_results = 0;
    n_mismatch = 0;
    tx_idle_pct = 21;
    rx_idle_pct = 79;

    // Directed rows; the first three have results that follow from reset state
    dir_tab = '{
      ex_typed(imm_op(E_ADDI, 12'hFFF, ZR_REG, 5'd1),
               '{64'h400004, 1'b0, 1'b1, 5'd1, 64'hFFF, 4'h0, 1'b0}),
      ex_typed(movz(2'd3, 16'hFFFF, 5'd2),
               '{64'h400008, 1'b0, 1'b1, 5'd2, 64'hFFFF_0000_0000_0000, 4'h0, 1'b0}),
      // compare form: flags only
      ex_typed(imm_op(E_SUBIS, 12'hFFF, 5'd1, ZR_REG),
               '{64'h40000C, 1'b0, 1'b0, 5'd0, 64'd0, 4'b0110, 1'b0}),
      ex(cbr(E_BCOND, 19'd2, COND_EQ)),
      ex(rrr(E_ADDS, 5'd2, 6'h3F, 5'd2, 5'd3)),            // carry, no overflow
      ex(rrr(E_SUBS, 5'd1, 6'd0, ZR_REG, ZR_REG)),
      ex(imm_op(E_SUBI, 12'd1, ZR_REG, 5'd5)),             // all ones
      ex(movz(2'd3, 16'h8000, 5'd6)),                      // most negative
      ex(rrr(E_DIV, 5'd5, FLD_SDIV, 5'd6, 5'd7)),          // min / -1
      ex(rrr(E_DIV, ZR_REG, FLD_UDIV, 5'd1, 5'd8)),        // divide by zero
      ex(rrr(E_MUL, 5'd1, FLD_MUL, 5'd5, 5'd9)),
      ex(rrr(E_ANDS, 5'd5, 6'h3F, 5'd2, 5'd10)),
      ex(rrr(E_EOR, 5'd5, 6'd0, 5'd1, 5'd11)),
      ex(shimm(6'd0, 6'd0, 5'd5, 5'd13)),                  // LSL by zero
      ex(shimm(6'h3F, FLD_LSR, 5'd5, 5'd14)),
      pre(10'd1023, 32'hFFFF_FFFF),
      pre(10'd0, 32'h1234_5678),
      ex(movz(2'd1, 16'h1000, 5'd15)),                     // data window base
      ex(mem_op(E_STUR, 9'h1FC, 5'd15, 5'd5)),             // half below the window
      ex(mem_op(E_STURB, 9'h0FF, 5'd15, 5'd1)),
      ex(mem_op(E_STURH, 9'h003, 5'd15, 5'd9)),
      ex(mem_op(E_LDUR, 9'h1FF, 5'd15, 5'd16)),
      ex(mem_op(E_LDURH, 9'h002, 5'd15, 5'd17)),
      ex(cbr(E_CBNZ, 19'h7FFFF, 5'd5)),
      ex({E_BL, 26'h3FF_FFFF}),
      ex(rrr(E_BR, 5'd0, 6'd0, 5'd1, 5'd0)),
      ex(32'hFFFF_FFFF)
    };

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[i]) send_item(dir_tab[i]);
    random_items(400);

    // extremes of both registers, sender idles more than receiver
    drain_and_config(CFG_START_PC, 32'hFFFF_FFFF);
    drain_and_config(CFG_DATA_BASE, 32'h0000_0000);
    tx_idle_pct = 79;
    rx_idle_pct = 21;
    random_items(400);

    drain_and_config(CFG_START_PC, 32'h0000_0000);
    drain_and_config(CFG_DATA_BASE, 32'hFFFF_FFFF);
    random_items(150);

    // random settings, no idling on either side
    drain_and_config(CFG_START_PC, $urandom);
    drain_and_config(CFG_DATA_BASE, $urandom);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_items(250);

    // halt, then show that instructions are ignored and a preload still completes
    send_item(ex({E_HLT, 21'd0}));
    repeat (4) send_item(ex(rand_instr()));
    send_item(pre(10'($urandom), $urandom));
    send_item(ex($urandom));
    in_valid_i <= 1'b0;

    wait (expected_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Ran %0d items (directed, ALU/divide/memory/branch mixes, halt) under",
             n_items);
    $display("four register settings and three idling modes; %0d results, %0d mismatches",
             n_results, n_mismatch);
    if (n_mismatch == 0 && expected_q.size() == 0) begin
      $display("PASS arm64_subset_execute_core");
    end else begin
      $display("FAIL arm64_subset_execute_core");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/ase_pkg.sv
rtl/ase_front.sv
rtl/ase_queue.sv
rtl/ase_div.sv
rtl/ase_back.sv
rtl/arm64_subset_execute_core.sv
rtl/ase_checker.sv
tb/tb_arm64_subset_execute_core.sv
